[rtl/slcq_pkg.sv]
// Package for the serial line command queue: payload and control types,
// character constants and the keyword table. Depends on nothing.
`default_nettype none

package slcq_pkg;

	localparam int SLOT_COUNT_DEF  = 8;
	localparam int LINE_LENGTH_DEF = 32;

	localparam int KW_COUNT = 8;
	localparam int KW_MAX   = 22;
	localparam int KI_W     = $clog2(KW_MAX + 1);

	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;

	localparam logic [KI_W-1:0] KW_LEN [KW_COUNT] = '{
		KI_W'(17), KI_W'(18), KI_W'(21), KI_W'(11),
		KI_W'(22), KI_W'(11), KI_W'(13), KI_W'(14)
	};

	typedef logic [2:0] mode_t;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic       byte_dropped;
		logic       line_closed;
		logic       line_consumed;
		logic [2:0] mode_code;
		logic [2:0] lines_waiting;
	} res_t;

	typedef struct packed {
		logic take;
		logic start;
		logic step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic proc_pending;
		logic match_done;
	} sts_t;

	// Character k of keyword w; zero past the end of the keyword.
	function automatic logic [7:0] kw_char(input mode_t w, input logic [KI_W-1:0] k);
		logic [KW_MAX*8-1:0] text;
		logic [KI_W-1:0]     len;
		logic [KI_W-1:0]     pos;
		unique case (w)
			3'd0: text = {"led_", "shift_", "left_", "on"};
			3'd1: text = {"led_", "shift_", "right_", "on"};
			3'd2: text = {"led_", "shift_", "left_", "keepon"};
			3'd3: text = {"led_", "all_", "off"};
			3'd4: text = {"led_", "shift_", "right_", "keepon"};
			3'd5: text = {"led_", "all_", "off"};
			3'd6: text = {"led_", "flower_", "on"};
			3'd7: text = {"led_", "flower_", "off"};
		endcase
		len = KW_LEN[w];
		pos = len - k - KI_W'(1);
		if (k < len) begin
			kw_char = text[{pos, 3'b000} +: 8];
		end else begin
			kw_char = 8'h00;
		end
	endfunction

endpackage

`default_nettype wire

[rtl/slcq_chan_if.sv]
// Valid/ready channel carrying one request or result payload.
// The payload type is set where the channel is instantiated.
`default_nettype none

interface slcq_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/slcq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module slcq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

`default_nettype wire

[rtl/slcq_ctrl.sv]
// Controller state machine of the serial line command queue.
// Depends on slcq_pkg for the command and status structs.
`default_nettype none

module slcq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output slcq_pkg::cmd_t     cmd,
	input  wire slcq_pkg::sts_t sts
);
	import slcq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DECIDE = 4'b0010,
		S_MATCH  = 4'b0100,
		S_COMMIT = 4'b1000
	} state_t;

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   commit_ok;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	// A result may be written while the previous one is being taken.
	assign commit_ok = (state_q == S_COMMIT) && (!out_valid_q || out_ready);

	assign cmd.take   = in_valid && in_ready;
	assign cmd.start  = (state_q == S_DECIDE) && sts.proc_pending;
	assign cmd.step   = (state_q == S_MATCH);
	assign cmd.commit = commit_ok;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_n = S_DECIDE;
			end
			S_DECIDE: begin
				state_n = sts.proc_pending ? S_MATCH : S_COMMIT;
			end
			S_MATCH: begin
				if (sts.match_done) state_n = S_COMMIT;
			end
			S_COMMIT: begin
				if (commit_ok) state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (commit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

`default_nettype wire

[rtl/slcq_datapath.sv]
// Datapath of the serial line command queue: ring pointers, line RAM,
// keyword matcher and result register. Depends on slcq_pkg and slcq_ram.
`default_nettype none

module slcq_datapath #(
	parameter int SLOT_COUNT  = slcq_pkg::SLOT_COUNT_DEF,
	parameter int LINE_LENGTH = slcq_pkg::LINE_LENGTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire slcq_pkg::req_t in_item,
	output slcq_pkg::res_t      out_item,
	input  wire slcq_pkg::cmd_t cmd,
	output slcq_pkg::sts_t      sts
);
	import slcq_pkg::*;

	localparam int SW    = $clog2(SLOT_COUNT);
	localparam int PW    = $clog2(LINE_LENGTH);
	localparam int DEPTH = SLOT_COUNT * LINE_LENGTH;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] LINE_LEN_A = AW'(LINE_LENGTH);

	req_t                item_q;
	res_t                out_q;
	logic [PW-1:0]       wpos_q, wpos_n;
	logic [SW-1:0]       head_q, head_n, tail_q, tail_n;
	logic [SW-1:0]       next_head, next_tail;
	mode_t               mode_q, mode_n;
	logic [KI_W-1:0]     rd_idx_q, cmp_idx_q;
	logic [KW_COUNT-1:0] alive_q, alive_n, pend_n;
	logic [7:0]          rd_data;
	logic [AW-1:0]       head_base, tail_base;
	logic                wr_en;
	logic [7:0]          wr_data;
	logic                ring_full, is_term, line_full, queue_busy;
	logic                dropped, closed, consumed;
	mode_t               hit_code;
	logic [SW:0]         cnt;

	assign head_base = AW'(head_q) * LINE_LEN_A;
	assign tail_base = AW'(tail_q) * LINE_LEN_A;

	slcq_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tail_base + AW'(wpos_q)),
		.wr_data (wr_data),
		.rd_addr (head_base + AW'(rd_idx_q)),
		.rd_data (rd_data)
	);

	// Keyword comparison: one stored byte against every keyword per cycle.
	always_comb begin
		for (int w = 0; w < KW_COUNT; w++) begin
			if (cmp_idx_q < KW_LEN[w]) begin
				alive_n[w] = alive_q[w] && (rd_data == kw_char(mode_t'(w), cmp_idx_q));
			end else begin
				alive_n[w] = alive_q[w];
			end
			pend_n[w] = alive_n[w] &&
				(({1'b0, cmp_idx_q} + (KI_W+1)'(1)) < {1'b0, KW_LEN[w]});
		end
	end

	// The first keyword in table order wins, so the repeated keyword never does.
	always_comb begin
		hit_code = '0;
		for (int w = KW_COUNT - 1; w >= 0; w--) begin
			if (alive_q[w]) hit_code = mode_t'(w);
		end
	end

	assign queue_busy       = (head_q != tail_q);
	assign sts.proc_pending = item_q.action && queue_busy;
	assign sts.match_done   = (pend_n == '0) || (cmp_idx_q == KI_W'(KW_MAX - 1));

	assign next_tail = (tail_q == SW'(SLOT_COUNT - 1)) ? '0 : tail_q + SW'(1);
	assign next_head = (head_q == SW'(SLOT_COUNT - 1)) ? '0 : head_q + SW'(1);
	assign ring_full = (next_tail == head_q);
	assign is_term   = (item_q.rx_byte == CHAR_LF) || (item_q.rx_byte == CHAR_CR);
	assign line_full = (wpos_q >= PW'(LINE_LENGTH - 1));

	always_comb begin
		wpos_n   = wpos_q;
		head_n   = head_q;
		tail_n   = tail_q;
		mode_n   = mode_q;
		wr_en    = 1'b0;
		wr_data  = item_q.rx_byte;
		dropped  = 1'b0;
		closed   = 1'b0;
		consumed = 1'b0;
		if (!item_q.action) begin
			if (ring_full) begin
				dropped = 1'b1;
			end else if (is_term) begin
				// The terminator is stored as a zero so matching stops there.
				wr_en   = cmd.commit;
				wr_data = 8'h00;
				wpos_n  = '0;
				tail_n  = next_tail;
				closed  = 1'b1;
			end else if (line_full) begin
				dropped = 1'b1;
			end else begin
				wr_en  = cmd.commit;
				wpos_n = wpos_q + PW'(1);
			end
		end else if (queue_busy) begin
			if (|alive_q) mode_n = hit_code;
			head_n   = next_head;
			consumed = 1'b1;
		end
	end

	assign cnt = {1'b0, tail_n} - {1'b0, head_n} +
		((tail_n < head_n) ? (SW+1)'(SLOT_COUNT) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			mode_q <= '0;
		end else if (cmd.commit) begin
			wpos_q <= wpos_n;
			head_q <= head_n;
			tail_q <= tail_n;
			mode_q <= mode_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_q   <= in_item;
			rd_idx_q <= '0;
		end
		if (cmd.start) begin
			alive_q   <= '1;
			cmp_idx_q <= rd_idx_q;
			rd_idx_q  <= rd_idx_q + KI_W'(1);
		end
		if (cmd.step) begin
			alive_q   <= alive_n;
			cmp_idx_q <= rd_idx_q;
			rd_idx_q  <= rd_idx_q + KI_W'(1);
		end
		if (cmd.commit) begin
			out_q.byte_dropped  <= dropped;
			out_q.line_closed   <= closed;
			out_q.line_consumed <= consumed;
			out_q.mode_code     <= mode_n;
			out_q.lines_waiting <= 3'(cnt);
		end
	end

	assign out_item = out_q;
endmodule

`default_nettype wire

[rtl/serial_line_command_queue_top.sv]
// Top level of the serial line command queue.
// Depends on slcq_pkg, slcq_chan_if, slcq_ctrl and slcq_datapath.
`default_nettype none

// Received bytes are gathered into a ring of SLOT_COUNT lines of LINE_LENGTH
// bytes held in one RAM; a newline or carriage return closes a line. A
// process request compares the oldest line with the command keywords and,
// on a match, updates the mode code, and every request gives exactly one
// result. A byte request, or a process request with no line waiting, passes
// through the decide and commit states. A process request with a line
// waiting also passes through the match state, where at most 22 stored bytes
// are compared, the length of the longest keyword: the line RAM's single
// read port delivers one byte per cycle to the keyword comparators, and
// comparison stops as soon as no keyword still has characters left to
// match. The next request is taken in the cycle after the result is written,
// so the block takes no new request until the current one is through, and
// the commit waits while an earlier result is still waiting to be taken.
// A new request is taken while the previous result waits in the output
// register.
module serial_line_command_queue_top #(
	parameter int SLOT_COUNT  = slcq_pkg::SLOT_COUNT_DEF,
	parameter int LINE_LENGTH = slcq_pkg::LINE_LENGTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	slcq_chan_if.sink   req,
	slcq_chan_if.source result
);
	import slcq_pkg::*;

	cmd_t cmd;
	sts_t sts;
	req_t req_item;
	res_t res_item;

	assign req_item       = req.payload;
	assign result.payload = res_item;

	slcq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	slcq_datapath #(
		.SLOT_COUNT  (SLOT_COUNT),
		.LINE_LENGTH (LINE_LENGTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (req_item),
		.out_item (res_item),
		.cmd      (cmd),
		.sts      (sts)
	);
endmodule

`default_nettype wire

[tb/sv/slcq_status_checker.sv]
`timescale 1ns / 100ps
// Status checker for the serial line command queue: keeps its own copy of the
// line ring and the keyword decode, and compares every result with it.
// Depends on slcq_pkg.
module slcq_status_checker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	input  wire logic           req_ready,
	input  wire slcq_pkg::req_t req_payload,
	input  wire logic           res_valid,
	input  wire logic           res_ready,
	input  wire slcq_pkg::res_t res_payload,
	output int                  failures,
	output int                  pending
);
	import slcq_pkg::*;

	localparam int SLOTS = SLOT_COUNT_DEF;
	localparam int LEN   = LINE_LENGTH_DEF;

	typedef logic [$clog2(SLOTS)-1:0] slot_t;
	typedef logic [$clog2(LEN)-1:0]   pos_t;

	string cmd_words [KW_COUNT] = '{
		string'({"led_", "shift_", "left_", "on"}),
		string'({"led_", "shift_", "right_", "on"}),
		string'({"led_", "shift_", "left_", "keepon"}),
		string'({"led_", "all_", "off"}),
		string'({"led_", "shift_", "right_", "keepon"}),
		string'({"led_", "all_", "off"}),
		string'({"led_", "flower_", "on"}),
		string'({"led_", "flower_", "off"})
	};

	logic [7:0] line_mem [SLOTS][LEN];
	pos_t       wr_pos;
	slot_t      head;
	slot_t      tail;
	mode_t      mode;
	res_t       awaited_status [$];
	int         results_seen;

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		failures++;
	endtask

	task automatic check_field(input string field, input int got, input int want);
		if (got != want) begin
			report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
				results_seen, field, got, want));
		end
	endtask

	function automatic logic line_starts_with(input slot_t s, input string word);
		for (int k = 0; k < word.len(); k++) begin
			if (k >= LEN || line_mem[s][k] != word[k]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic slot_t slot_after(input slot_t s);
		return (s == slot_t'(SLOTS - 1)) ? '0 : slot_t'(s + 1'b1);
	endfunction

	// Applies one request to the mirrored state and returns the status it yields.
	function automatic res_t next_status(input req_t r);
		res_t  st;
		slot_t nxt;
		st = '0;
		if (!r.action) begin
			nxt = slot_after(tail);
			if (nxt == head) begin
				st.byte_dropped = 1'b1;
			end else if (r.rx_byte == CHAR_LF || r.rx_byte == CHAR_CR) begin
				// The write position never passes LEN-1, so the terminator always fits.
				line_mem[tail][wr_pos] = 8'h00;
				wr_pos = '0;
				tail = nxt;
				st.line_closed = 1'b1;
			end else if (wr_pos == pos_t'(LEN - 1)) begin
				st.byte_dropped = 1'b1;
			end else begin
				line_mem[tail][wr_pos] = r.rx_byte;
				wr_pos = pos_t'(wr_pos + 1'b1);
			end
		end else if (head != tail) begin
			for (int w = 0; w < KW_COUNT; w++) begin
				if (line_starts_with(head, cmd_words[w])) begin
					mode = mode_t'(w);
					break;
				end
			end
			head = slot_after(head);
			st.line_consumed = 1'b1;
		end
		st.mode_code = mode;
		st.lines_waiting = 3'((int'(tail) + SLOTS - int'(head)) % SLOTS);
		return st;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			wr_pos = '0;
			head = '0;
			tail = '0;
			mode = '0;
			awaited_status.delete();
			results_seen = 0;
			failures = 0;
			pending = 0;
		end else begin
			// A result can never belong to a request taken at the same edge.
			if (res_valid && res_ready) begin
				if (awaited_status.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing awaited: %h",
						results_seen, res_payload));
				end else begin
					want = awaited_status.pop_front();
					check_field("byte_dropped", res_payload.byte_dropped, want.byte_dropped);
					check_field("line_closed", res_payload.line_closed, want.line_closed);
					check_field("line_consumed", res_payload.line_consumed,
						want.line_consumed);
					check_field("mode_code", res_payload.mode_code, want.mode_code);
					check_field("lines_waiting", res_payload.lines_waiting,
						want.lines_waiting);
				end
				results_seen++;
			end
			if (req_valid && req_ready) begin
				awaited_status.push_back(next_status(req_payload));
			end
			pending = awaited_status.size();
		end
	end

endmodule

[tb/sv/serial_line_command_queue_top_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the serial line command queue: clock, reset, request
// stimulus, result back-pressure, watchdog and verdict.
// Depends on slcq_pkg, slcq_chan_if, serial_line_command_queue_top and slcq_status_checker.
module serial_line_command_queue_top_tb;
	import slcq_pkg::*;

	localparam int RANDOM_ITEMS = 320;
	localparam int IDLE_LIMIT   = 3000;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 30;

	logic clk = 1'b0;
	logic arst_n;
	logic calm = 1'b0;
	logic hold_rx = 1'b0;
	int   failures;
	int   pending;
	int   sent_items = 0;
	int   idle_cycles = 0;

	string cmd_words [KW_COUNT] = '{
		string'({"led_", "shift_", "left_", "on"}),
		string'({"led_", "shift_", "right_", "on"}),
		string'({"led_", "shift_", "left_", "keepon"}),
		string'({"led_", "all_", "off"}),
		string'({"led_", "shift_", "right_", "keepon"}),
		string'({"led_", "all_", "off"}),
		string'({"led_", "flower_", "on"}),
		string'({"led_", "flower_", "off"})
	};

	slcq_chan_if #(.payload_t(req_t)) req_ch ();
	slcq_chan_if #(.payload_t(res_t)) res_ch ();

	serial_line_command_queue_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.result (res_ch)
	);

	slcq_status_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_ch.valid),
		.req_ready   (req_ch.ready),
		.req_payload (req_ch.payload),
		.res_valid   (res_ch.valid),
		.res_ready   (res_ch.ready),
		.res_payload (res_ch.payload),
		.failures    (failures),
		.pending     (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Result side: random stalls, none while calm, and one long hold-off on demand.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx && !hold_done) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				res_ch.ready <= calm || ($urandom_range(99) >= 9);
			end
		end
	end

	task automatic put_request(input logic act, input logic [7:0] value);
		req_t r;
		r.action = act;
		r.rx_byte = value;
		if (!calm && $urandom_range(99) < 9) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.payload <= r;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sent_items++;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			put_request(1'b0, 8'(s[i]));
		end
	endtask

	task automatic put_process();
		put_request(1'b1, 8'($urandom_range(255)));
	endtask

	function automatic logic [7:0] data_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == CHAR_LF || b == CHAR_CR);
		return b;
	endfunction

	function automatic logic [7:0] any_terminator();
		return $urandom_range(1) ? CHAR_LF : CHAR_CR;
	endfunction

	task automatic wait_all_results();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	initial begin
		int    first;
		int    done;
		int    line_no;
		int    kind;
		int    cut;
		bit    paused;
		string word;
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.payload <= '0;
		paused = 1'b0;
		line_no = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Process request with nothing queued.
		put_request(1'b1, 8'h00);
		put_text(cmd_words[3]);
		put_request(1'b0, CHAR_LF);
		put_request(1'b1, 8'hFF);
		put_text(cmd_words[7]);
		put_request(1'b0, CHAR_CR);
		put_text(cmd_words[4]);
		put_request(1'b0, CHAR_LF);
		put_process();
		put_process();
		// A zero byte up front stops matching, so the mode stays as it was.
		put_request(1'b0, 8'h00);
		put_request(1'b0, 8'hFF);
		put_text(cmd_words[6]);
		put_request(1'b0, CHAR_LF);
		put_process();
		// Overlong line: bytes beyond LINE_LENGTH-1 in a slot are dropped.
		put_text(cmd_words[6]);
		repeat (24) put_request(1'b0, 8'h61);
		put_request(1'b0, CHAR_CR);
		put_process();
		// Fill the ring with empty lines; further bytes and terminators are dropped.
		repeat (7) put_request(1'b0, CHAR_LF);
		put_request(1'b0, 8'h78);
		put_request(1'b0, CHAR_CR);
		repeat (8) put_process();

		first = sent_items;
		done = 0;
		while (done < RANDOM_ITEMS) begin
			if (done > 70) begin
				hold_rx <= 1'b1;
			end
			if (!paused && done > 170) begin
				wait_all_results();
				paused = 1'b1;
			end
			calm <= (done > 200 && done < 270);

			kind = $urandom_range(99);
			word = cmd_words[$urandom_range(KW_COUNT - 1)];
			if (kind < 8) begin
				// Lone noise: any byte, terminators included, or a stray process request.
				if ($urandom_range(1)) begin
					put_request(1'b0, 8'($urandom_range(255)));
				end else begin
					put_process();
				end
			end else begin
				if (kind < 55) begin
					put_text(word);
					repeat ($urandom_range(0, 3)) put_request(1'b0, data_byte());
				end else if (kind < 75) begin
					cut = $urandom_range(0, word.len() - 1);
					put_text(word.substr(0, cut));
					put_request(1'b0, data_byte());
				end else if (kind < 92) begin
					repeat ($urandom_range(0, 6)) put_request(1'b0, data_byte());
				end else begin
					repeat ($urandom_range(28, 40)) put_request(1'b0, data_byte());
				end
				put_request(1'b0, any_terminator());
				line_no++;
				// Alternate between letting lines pile up and draining them.
				if ($urandom_range(99) < (((line_no / 8) % 2) ? 70 : 5)) begin
					repeat ($urandom_range(1, 3)) put_process();
				end
			end
			done = sent_items - first;
		end

		wait_all_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[serial_line_command_queue_top.f]
rtl/slcq_pkg.sv
rtl/slcq_chan_if.sv
rtl/slcq_ram.sv
rtl/slcq_ctrl.sv
rtl/slcq_datapath.sv
rtl/serial_line_command_queue_top.sv
tb/sv/slcq_status_checker.sv
tb/sv/serial_line_command_queue_top_tb.sv
